FILE: hdl/assert_macros.svh
// Assertion macros shared by the mixer RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define MWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define MWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mwm_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the wheel speed mixer.
// No dependencies; every other file of the mixer but assert_macros.svh imports it.
package mwm_pkg;

  // Field widths
  localparam int STICK_W     = 11;
  localparam int YAW_W       = 16;
  localparam int WHEEL_W     = 16;
  localparam int SPEED_MAX_W = 14;
  localparam int GAIN_W      = 10;
  localparam int GAIN_FRAC   = 8;

  localparam int TRIG_FRACTION_BITS_DEFAULT = 15;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPEED_MAX     = 1'b0,
    REG_ROTATION_GAIN = 1'b1
  } reg_idx_t;

  localparam logic [SPEED_MAX_W-1:0] SPEED_MAX_RESET     = 14'd2000;
  localparam logic [GAIN_W-1:0]      ROTATION_GAIN_RESET = 10'd307;

  typedef struct packed {
    logic [SPEED_MAX_W-1:0] speed_max;
    logic [GAIN_W-1:0]      rotation_gain;
  } cfg_t;

  // Stick scaling: trunc(stick * speed_max / 660)
  localparam int STICK_FULL     = 660;
  localparam int NUM_STICKS     = 3;
  localparam int SCALE_PROD_W   = STICK_W + SPEED_MAX_W + 1;
  localparam int SCALE_ABS_W    = STICK_W + SPEED_MAX_W - 1;
  localparam int SCALE_RECIP_W  = 15;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP =
    SCALE_RECIP_W'((64'd1 << SCALE_ABS_W) / STICK_FULL);
  localparam int SPEED_W        = 16;
  localparam int ROT_W          = SPEED_W + GAIN_W + 1;

  // Angle handling in centidegrees
  localparam int ANGLE_TURN     = 36000;
  localparam int ANGLE_HALF     = 18000;
  localparam int ANGLE_QUARTER  = 9000;
  localparam int THETA_W        = YAW_W + 1;
  localparam int ANG_W          = THETA_W + 2;
  localparam int ANG_MAG_W      = 14;

  // Binary angle: z = |m| * 2^32 / 36000 = |m| * Z_INT + |m| * Z_REM / 36000
  localparam longint unsigned BAM_TURN = 64'd1 << 32;
  localparam int Z_INT_W   = 17;
  localparam int Z_REM_W   = 15;
  localparam logic [Z_INT_W-1:0] Z_INT = Z_INT_W'(BAM_TURN / ANGLE_TURN);
  localparam logic [Z_REM_W-1:0] Z_REM = Z_REM_W'(BAM_TURN % ANGLE_TURN);
  localparam int ZI_W      = ANG_MAG_W + Z_INT_W;
  localparam int ZF_W      = ANG_MAG_W + Z_REM_W;
  localparam int Z_RECIP_W = 14;
  localparam logic [Z_RECIP_W-1:0] Z_RECIP = Z_RECIP_W'((64'd1 << ZF_W) / ANGLE_TURN);
  localparam int ZQ_W      = 13;

  // CORDIC in Q30
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_W        = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

  // Rotation and wheel mixing
  localparam int VEL_W  = 18;
  localparam int WSUM_W = 28;
  localparam int NUM_WHEELS = 4;

  // Data that rides along the CORDIC pipe
  typedef struct packed {
    logic signed [SPEED_W-1:0] sx;
    logic signed [SPEED_W-1:0] sy;
    logic signed [ROT_W-1:0]   rot;
    logic                      flip;
  } side_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [31:0] mwm_atan(input int unsigned i);
    case (i)
      0:       return 32'd536870912;
      1:       return 32'd316933406;
      2:       return 32'd167458907;
      3:       return 32'd85004756;
      4:       return 32'd42667331;
      5:       return 32'd21354465;
      6:       return 32'd10679838;
      7:       return 32'd5340245;
      8:       return 32'd2670163;
      9:       return 32'd1335087;
      10:      return 32'd667544;
      11:      return 32'd333772;
      12:      return 32'd166886;
      13:      return 32'd83443;
      14:      return 32'd41722;
      15:      return 32'd20861;
      16:      return 32'd10430;
      17:      return 32'd5215;
      18:      return 32'd2608;
      19:      return 32'd1304;
      20:      return 32'd652;
      21:      return 32'd326;
      22:      return 32'd163;
      23:      return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

endpackage

FILE: hdl/mwm_cmd_if.sv
// Input channel of the wheel speed mixer: stick channels and yaw angles.
// Depends on mwm_pkg for the field widths.
interface mwm_cmd_if;
  import mwm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [STICK_W-1:0] stick_lateral;
  logic signed [STICK_W-1:0] stick_forward;
  logic signed [STICK_W-1:0] stick_rotate;
  logic signed [YAW_W-1:0]   chassis_yaw;
  logic signed [YAW_W-1:0]   gimbal_yaw;

  modport source (
    output valid, stick_lateral, stick_forward, stick_rotate, chassis_yaw, gimbal_yaw,
    input  ready
  );

  modport sink (
    input  valid, stick_lateral, stick_forward, stick_rotate, chassis_yaw, gimbal_yaw,
    output ready
  );
endinterface

FILE: hdl/mwm_wheel_if.sv
// Output channel of the wheel speed mixer: four wheel target speeds.
// Depends on mwm_pkg for the field widths.
interface mwm_wheel_if;
  import mwm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WHEEL_W-1:0] wheel_speed_0;
  logic signed [WHEEL_W-1:0] wheel_speed_1;
  logic signed [WHEEL_W-1:0] wheel_speed_2;
  logic signed [WHEEL_W-1:0] wheel_speed_3;

  modport source (
    output valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
    input  ready
  );

  modport sink (
    input  valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
    output ready
  );
endinterface

FILE: hdl/mecanum_wheel_speed_mixer.sv
// Mecanum wheel speed mixer. Takes one command word per cycle while the skid register is free
// (three stick channels and two yaw angles) and returns one word of four int16 wheel target
// speeds through the stick scaling and angle reduction stages, 24 CORDIC stages, 1 rounding
// stage, 2 rotation stages and the output register. The whole pipe advances together; an
// output skid register lets one more word finish while the sink holds off, and cmd.ready
// drops only once that skid register is full. Configure through APB while idle.
// Depends on mwm_pkg, mwm_cmd_if, mwm_wheel_if, mwm_regs, mwm_cordic, assert_macros.svh.
module mecanum_wheel_speed_mixer #(
  parameter int TRIG_FRACTION_BITS = mwm_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  mwm_cmd_if.sink                         cmd,
  mwm_wheel_if.source                     wheel,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mwm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mwm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mwm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mwm_pkg::*;

  `include "assert_macros.svh"

  localparam int F      = TRIG_FRACTION_BITS;
  localparam int CS_W   = F + 2;
  localparam int PROD_W = CS_W + SPEED_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int LIN_W  = VEL_W + 1;
  localparam int IDX_LAT = 0;
  localparam int IDX_FWD = 1;
  localparam int IDX_ROT = 2;

  localparam logic signed [NUM_W-1:0]  TRUNC_BIAS = NUM_W'((64'd1 << F) - 1);
  localparam logic signed [ANG_W-1:0]  A_TURN     = ANG_W'(ANGLE_TURN);
  localparam logic signed [ANG_W-1:0]  A_HALF     = ANG_W'(ANGLE_HALF);
  localparam logic signed [ANG_W-1:0]  A_QUARTER  = ANG_W'(ANGLE_QUARTER);
  localparam logic signed [ANG_W-1:0]  A_OFFSET   = ANG_W'(2 * ANGLE_TURN);
  localparam logic signed [WSUM_W-1:0] W_HI       = WSUM_W'(32767);
  localparam logic signed [WSUM_W-1:0] W_LO       = WSUM_W'(-32768);
  localparam logic signed [WSUM_W-1:0] W_BIAS     = WSUM_W'((1 << GAIN_FRAC) - 1);

  cfg_t cfg;

  mwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipe advances whenever the skid register is free
  logic en;
  logic skid_valid;
  assign en        = !skid_valid;
  assign cmd.ready = en;

  // ---------------- stage 1: products and angle difference ----------------
  logic signed [STICK_W-1:0]      stick_in [NUM_STICKS];
  logic                           s1_valid;
  logic signed [SCALE_PROD_W-1:0] s1_prod [NUM_STICKS];
  logic signed [THETA_W-1:0]      s1_theta;

  assign stick_in[IDX_LAT] = cmd.stick_lateral;
  assign stick_in[IDX_FWD] = cmd.stick_forward;
  assign stick_in[IDX_ROT] = cmd.stick_rotate;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        s1_prod[k] <= stick_in[k] * $signed({1'b0, cfg.speed_max});
      end
      // theta = -(chassis - gimbal)
      s1_theta <= THETA_W'(cmd.gimbal_yaw) - THETA_W'(cmd.chassis_yaw);
    end
  end

  // ---------------- stage 2: reciprocal estimate, angle fold ----------------
  logic [SCALE_ABS_W-1:0]               mag_next [NUM_STICKS];
  logic [SCALE_ABS_W+SCALE_RECIP_W-1:0] recip_prod [NUM_STICKS];
  logic signed [ANG_W-1:0]              ang;
  logic                                 flip_next;
  logic                                 s2_valid;
  logic [SCALE_ABS_W-1:0]               s2_mag [NUM_STICKS];
  logic                                 s2_neg [NUM_STICKS];
  logic [SCALE_RECIP_W-1:0]             s2_q0 [NUM_STICKS];
  logic [ANG_MAG_W-1:0]                 s2_amag;
  logic                                 s2_aneg;
  logic                                 s2_flip;

  always_comb begin
    for (int k = 0; k < NUM_STICKS; k++) begin
      mag_next[k]   = s1_prod[k][SCALE_PROD_W-1] ? SCALE_ABS_W'(-s1_prod[k])
                                                 : SCALE_ABS_W'(s1_prod[k]);
      recip_prod[k] = mag_next[k] * SCALE_RECIP;
    end
    // Reduce to [0, 36000), center on zero, then fold into +-9000
    ang = ANG_W'(s1_theta) + A_OFFSET;
    if (ang >= A_TURN) ang = ang - A_TURN;
    if (ang >= A_TURN) ang = ang - A_TURN;
    if (ang >= A_TURN) ang = ang - A_TURN;
    if (ang >= A_HALF) ang = ang - A_TURN;
    flip_next = 1'b0;
    if (ang > A_QUARTER) begin
      ang       = ang - A_HALF;
      flip_next = 1'b1;
    end else if (ang < -A_QUARTER) begin
      ang       = ang + A_HALF;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        s2_mag[k] <= mag_next[k];
        s2_neg[k] <= s1_prod[k][SCALE_PROD_W-1];
        s2_q0[k]  <= recip_prod[k][SCALE_ABS_W +: SCALE_RECIP_W];
      end
      s2_amag <= ang[ANG_W-1] ? ANG_MAG_W'(-ang) : ANG_MAG_W'(ang);
      s2_aneg <= ang[ANG_W-1];
      s2_flip <= flip_next;
    end
  end

  // ---------------- stage 3: quotient check product, angle split ----------------
  logic                     s3_valid;
  logic [SCALE_ABS_W-1:0]   s3_mag [NUM_STICKS];
  logic                     s3_neg [NUM_STICKS];
  logic [SCALE_RECIP_W-1:0] s3_q0 [NUM_STICKS];
  logic [SCALE_ABS_W-1:0]   s3_qd [NUM_STICKS];
  logic [ZI_W-1:0]          s3_zi;
  logic [ZF_W-1:0]          s3_zf;
  logic                     s3_aneg;
  logic                     s3_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        s3_mag[k] <= s2_mag[k];
        s3_neg[k] <= s2_neg[k];
        s3_q0[k]  <= s2_q0[k];
        s3_qd[k]  <= SCALE_ABS_W'(s2_q0[k] * SCALE_ABS_W'(STICK_FULL));
      end
      s3_zi   <= s2_amag * Z_INT;
      s3_zf   <= s2_amag * Z_REM;
      s3_aneg <= s2_aneg;
      s3_flip <= s2_flip;
    end
  end

  // ---------------- stage 4: corrected speeds, angle fraction estimate ----------------
  logic [SCALE_ABS_W-1:0]     rem_next [NUM_STICKS];
  logic [SCALE_RECIP_W-1:0]   q_next [NUM_STICKS];
  logic [ZF_W+Z_RECIP_W-1:0]  zrecip_prod;
  logic                       s4_valid;
  logic signed [SPEED_W-1:0]  s4_speed [NUM_STICKS];
  logic [ZI_W-1:0]            s4_zi;
  logic [ZF_W-1:0]            s4_zf;
  logic [ZQ_W-1:0]            s4_zq0;
  logic                       s4_aneg;
  logic                       s4_flip;

  always_comb begin
    for (int k = 0; k < NUM_STICKS; k++) begin
      rem_next[k] = s3_mag[k] - s3_qd[k];
      q_next[k]   = s3_q0[k] + SCALE_RECIP_W'(rem_next[k] >= SCALE_ABS_W'(STICK_FULL));
    end
    zrecip_prod = s3_zf * Z_RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        s4_speed[k] <= s3_neg[k] ? -SPEED_W'(q_next[k]) : SPEED_W'(q_next[k]);
      end
      s4_zi   <= s3_zi;
      s4_zf   <= s3_zf;
      s4_zq0  <= zrecip_prod[ZF_W +: ZQ_W];
      s4_aneg <= s3_aneg;
      s4_flip <= s3_flip;
    end
  end

  // ---------------- stage 5: rotate term, angle check product ----------------
  logic                      s5_valid;
  logic signed [SPEED_W-1:0] s5_sx;
  logic signed [SPEED_W-1:0] s5_sy;
  logic signed [ROT_W-1:0]   s5_rot;
  logic [ZI_W-1:0]           s5_zi;
  logic [ZF_W-1:0]           s5_zf;
  logic [ZQ_W-1:0]           s5_zq0;
  logic [ZF_W-1:0]           s5_zqd;
  logic                      s5_aneg;
  logic                      s5_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sx   <= s4_speed[IDX_LAT];
      s5_sy   <= s4_speed[IDX_FWD];
      s5_rot  <= s4_speed[IDX_ROT] * $signed({1'b0, cfg.rotation_gain});
      s5_zi   <= s4_zi;
      s5_zf   <= s4_zf;
      s5_zq0  <= s4_zq0;
      s5_zqd  <= ZF_W'(s4_zq0 * ZF_W'(ANGLE_TURN));
      s5_aneg <= s4_aneg;
      s5_flip <= s4_flip;
    end
  end

  // ---------------- stage 6: binary angle ----------------
  logic [ZF_W-1:0]            zrem_next;
  logic [ZI_W-1:0]            zmag_next;
  logic                       s6_valid;
  logic signed [CORDIC_W-1:0] s6_z;
  side_t                      s6_side;

  always_comb begin
    zrem_next = s5_zf - s5_zqd;
    zmag_next = s5_zi + ZI_W'(s5_zq0) + ZI_W'(zrem_next >= ZF_W'(ANGLE_TURN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_z         <= s5_aneg ? -CORDIC_W'(zmag_next) : CORDIC_W'(zmag_next);
      s6_side.sx   <= s5_sx;
      s6_side.sy   <= s5_sy;
      s6_side.rot  <= s5_rot;
      s6_side.flip <= s5_flip;
    end
  end

  // ---------------- CORDIC ----------------
  logic                   tr_valid;
  logic signed [CS_W-1:0] tr_cos;
  logic signed [CS_W-1:0] tr_sin;
  side_t                  tr_side;

  mwm_cordic #(
    .FRAC_BITS (F)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_valid),
    .in_angle  (s6_z),
    .in_side   (s6_side),
    .out_valid (tr_valid),
    .cos_q     (tr_cos),
    .sin_q     (tr_sin),
    .out_side  (tr_side)
  );

  // ---------------- rotation: products ----------------
  logic                     r1_valid;
  logic signed [PROD_W-1:0] r1_cx, r1_sy, r1_sx, r1_cy;
  logic signed [ROT_W-1:0]  r1_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= tr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_cx  <= tr_cos * tr_side.sx;
      r1_sy  <= tr_sin * tr_side.sy;
      r1_sx  <= tr_sin * tr_side.sx;
      r1_cy  <= tr_cos * tr_side.sy;
      r1_rot <= tr_side.rot;
    end
  end

  // ---------------- rotation: sums, truncate toward zero ----------------
  logic signed [NUM_W-1:0] nx, ny, nxb, nyb;
  logic                    r2_valid;
  logic signed [VEL_W-1:0] r2_vx, r2_vy;
  logic signed [ROT_W-1:0] r2_rot;

  always_comb begin
    nx  = NUM_W'(r1_cx) - NUM_W'(r1_sy);
    ny  = NUM_W'(r1_sx) + NUM_W'(r1_cy);
    nxb = nx[NUM_W-1] ? nx + TRUNC_BIAS : nx;
    nyb = ny[NUM_W-1] ? ny + TRUNC_BIAS : ny;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (en) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_vx  <= VEL_W'(nxb >>> F);
      r2_vy  <= VEL_W'(nyb >>> F);
      r2_rot <= r1_rot;
    end
  end

  // ---------------- wheel mix and saturation ----------------
  logic signed [LIN_W-1:0]   lin [NUM_WHEELS];
  logic signed [WSUM_W-1:0]  wsum [NUM_WHEELS];
  logic signed [WSUM_W-1:0]  wq [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] wheel_next [NUM_WHEELS];

  always_comb begin
    lin[0] =  LIN_W'(r2_vy) + LIN_W'(r2_vx);
    lin[1] = -LIN_W'(r2_vy) + LIN_W'(r2_vx);
    lin[2] = -LIN_W'(r2_vy) - LIN_W'(r2_vx);
    lin[3] =  LIN_W'(r2_vy) - LIN_W'(r2_vx);
    for (int k = 0; k < NUM_WHEELS; k++) begin
      wsum[k] = (WSUM_W'(lin[k]) <<< GAIN_FRAC) + WSUM_W'(r2_rot);
      wq[k]   = (wsum[k][WSUM_W-1] ? wsum[k] + W_BIAS : wsum[k]) >>> GAIN_FRAC;
      if (wq[k] > W_HI) begin
        wheel_next[k] = WHEEL_W'(W_HI);
      end else if (wq[k] < W_LO) begin
        wheel_next[k] = WHEEL_W'(W_LO);
      end else begin
        wheel_next[k] = WHEEL_W'(wq[k]);
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic                      out_valid;
  logic signed [WHEEL_W-1:0] out_data [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] skid_data [NUM_WHEELS];
  logic                      take;
  logic                      arrive;

  assign take   = out_valid && wheel.ready;
  assign arrive = en && r2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!out_valid || take) begin
        out_valid <= arrive;
      end else if (arrive) begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      // drain the skid word into the output slot
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!out_valid || take) begin
        out_data <= wheel_next;
      end else if (arrive) begin
        skid_data <= wheel_next;
      end
    end else if (take) begin
      out_data <= skid_data;
    end
  end

  assign wheel.valid         = out_valid;
  assign wheel.wheel_speed_0 = out_data[0];
  assign wheel.wheel_speed_1 = out_data[1];
  assign wheel.wheel_speed_2 = out_data[2];
  assign wheel.wheel_speed_3 = out_data[3];

  `MWM_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid word without output word")
  `MWM_ASSERT_NEXT(a_no_drop, arrive && out_valid && !wheel.ready, skid_valid,
    "finished word dropped while output stalled")
  `MWM_ASSERT_NEXT(a_skid_held, skid_valid && !take, skid_valid && out_valid,
    "skid word lost before output moved")
  `MWM_ASSERT_NEXT(a_pipe_frozen, !en, $stable(r2_valid) && $stable(s1_valid),
    "pipeline moved while skid full")
endmodule

FILE: hdl/mwm_regs.sv
// APB configuration registers of the mixer: speed_max and rotation_gain.
// Depends on mwm_pkg for the register map and cfg_t.
module mwm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mwm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mwm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mwm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mwm_pkg::cfg_t                   cfg
);
  import mwm_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_max     <= SPEED_MAX_RESET;
      cfg.rotation_gain <= ROTATION_GAIN_RESET;
    end else if (wr) begin
      case (idx)
        REG_SPEED_MAX:     cfg.speed_max     <= pwdata[SPEED_MAX_W-1:0];
        REG_ROTATION_GAIN: cfg.rotation_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_MAX:     prdata = APB_DATA_W'(cfg.speed_max);
      REG_ROTATION_GAIN: prdata = APB_DATA_W'(cfg.rotation_gain);
      default:           prdata = '0;
    endcase
  end
endmodule

FILE: hdl/mwm_cordic.sv
// Pipelined CORDIC: one rotation step per stage, then rounding to Q(FRAC_BITS),
// clamping and the half-plane sign flip. Depends on mwm_pkg.
module mwm_cordic #(
  parameter int FRAC_BITS = mwm_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [mwm_pkg::CORDIC_W-1:0]  in_angle,
  input  mwm_pkg::side_t                       in_side,
  output logic                                 out_valid,
  output logic signed [FRAC_BITS+1:0]          cos_q,
  output logic signed [FRAC_BITS+1:0]          sin_q,
  output mwm_pkg::side_t                       out_side
);
  import mwm_pkg::*;

  localparam int SHIFT = ANGLE_FRAC_BITS - FRAC_BITS;
  localparam int CS_W  = FRAC_BITS + 2;
  localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = CORDIC_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [CORDIC_W-1:0] ONE_Q      = CORDIC_W'(64'd1 << FRAC_BITS);

  logic signed [CORDIC_W-1:0] xs [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] ys [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] zs [CORDIC_STEPS];
  logic                       vs [CORDIC_STEPS];
  side_t                      ss [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CORDIC_W-1:0] ATAN_I = CORDIC_W'(mwm_atan(i));

    logic signed [CORDIC_W-1:0] x_prev;
    logic signed [CORDIC_W-1:0] y_prev;
    logic signed [CORDIC_W-1:0] z_prev;
    logic                       v_prev;
    side_t                      s_prev;

    if (i == 0) begin : g_first
      assign x_prev = CORDIC_X0;
      assign y_prev = '0;
      assign z_prev = in_angle;
      assign v_prev = in_valid;
      assign s_prev = in_side;
    end else begin : g_rest
      assign x_prev = xs[i-1];
      assign y_prev = ys[i-1];
      assign z_prev = zs[i-1];
      assign v_prev = vs[i-1];
      assign s_prev = ss[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else if (en) begin
        vs[i] <= v_prev;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i] <= s_prev;
        if (!z_prev[CORDIC_W-1]) begin
          xs[i] <= x_prev - (y_prev >>> i);
          ys[i] <= y_prev + (x_prev >>> i);
          zs[i] <= z_prev - ATAN_I;
        end else begin
          xs[i] <= x_prev + (y_prev >>> i);
          ys[i] <= y_prev - (x_prev >>> i);
          zs[i] <= z_prev + ATAN_I;
        end
      end
    end
  end

  logic signed [CORDIC_W-1:0] xr, yr, xc, yc;
  side_t                      last_side;

  assign last_side = ss[CORDIC_STEPS-1];

  always_comb begin
    xr = (xs[CORDIC_STEPS-1] + ROUND_BIAS) >>> SHIFT;
    yr = (ys[CORDIC_STEPS-1] + ROUND_BIAS) >>> SHIFT;
    xc = xr;
    yc = yr;
    if (xr > ONE_Q)  xc = ONE_Q;
    if (xr < -ONE_Q) xc = -ONE_Q;
    if (yr > ONE_Q)  yc = ONE_Q;
    if (yr < -ONE_Q) yc = -ONE_Q;
    if (last_side.flip) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q    <= CS_W'(xc);
      sin_q    <= CS_W'(yc);
      out_side <= last_side;
    end
  end
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for mecanum_wheel_speed_mixer: random and directed command words,
// a built-in wheel speed predictor, random stalls on both channels and APB setting changes.
// Depends on mwm_pkg, mwm_cmd_if, mwm_wheel_if and the mixer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  localparam int TRIG_FRAC = TRIG_FRACTION_BITS_DEFAULT;
  localparam longint CORDIC_START_X = 64'sd652032874;
  localparam longint BAM_PER_TURN = 64'sd4294967296;
  localparam int DRAIN_CYCLES = 40;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  localparam logic [0:CORDIC_STEPS-1][31:0] ATAN_TURN = {
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [STICK_W-1:0] lateral;
    logic signed [STICK_W-1:0] forward;
    logic signed [STICK_W-1:0] rotate;
    logic signed [YAW_W-1:0]   chassis;
    logic signed [YAW_W-1:0]   gimbal;
  } cmd_word_t;

  typedef logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel_set_t;

  logic clk;
  logic rst;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mwm_cmd_if   cmd_bus ();
  mwm_wheel_if wheel_bus ();

  mecanum_wheel_speed_mixer #(.TRIG_FRACTION_BITS(TRIG_FRAC)) uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus.sink),
    .wheel   (wheel_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the settings
  int speed_max_set = SPEED_MAX_RESET;
  int rotation_gain_set = ROTATION_GAIN_RESET;

  cmd_word_t  cmd_backlog [$];
  wheel_set_t due_wheels [$];
  cmd_word_t  fresh_cmd;
  cmd_word_t  seen_cmd;
  wheel_set_t got_wheels;

  int src_idle_pct = 25;
  int snk_idle_pct = 25;
  int error_count = 0;
  int words_in = 0;
  int words_out = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cos and sin of an angle in centidegrees, Q(TRIG_FRAC)
  function automatic void cordic_cos_sin(input longint cdeg, output longint cs,
                                         output longint sn);
    longint m, x, y, z, dx, dy, one, tmp;
    bit flip;
    int sh;
    sh = 30 - TRIG_FRAC;
    one = 64'sd1 << TRIG_FRAC;
    flip = 1'b0;
    m = cdeg % ANGLE_TURN;
    if (m < 0) m += ANGLE_TURN;
    if (m >= ANGLE_HALF) m -= ANGLE_TURN;
    // fold into +-90 degrees, flip the sign of both results for the far half plane
    if (m > ANGLE_QUARTER) begin
      m -= ANGLE_HALF;
      flip = 1'b1;
    end else if (m < -ANGLE_QUARTER) begin
      m += ANGLE_HALF;
      flip = 1'b1;
    end
    z = (m * BAM_PER_TURN) / ANGLE_TURN;
    x = CORDIC_START_X;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURN[i]);
      end
    end
    x = (x + (64'sd1 << (sh - 1))) >>> sh;
    y = (y + (64'sd1 << (sh - 1))) >>> sh;
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    if (flip) begin
      tmp = -x;
      x = tmp;
      tmp = -y;
      y = tmp;
    end
    cs = x;
    sn = y;
  endfunction

  function automatic wheel_set_t mix_wheels(input cmd_word_t w);
    longint sx, sy, wz, theta, cs, sn, vx, vy, rot, v;
    longint lin [NUM_WHEELS];
    wheel_set_t res;
    sx = (longint'($signed(w.lateral)) * speed_max_set) / STICK_FULL;
    sy = (longint'($signed(w.forward)) * speed_max_set) / STICK_FULL;
    wz = (longint'($signed(w.rotate)) * speed_max_set) / STICK_FULL;
    theta = -(longint'($signed(w.chassis)) - longint'($signed(w.gimbal)));
    cordic_cos_sin(theta, cs, sn);
    vx = (cs * sx - sn * sy) / (64'sd1 << TRIG_FRAC);
    vy = (sn * sx + cs * sy) / (64'sd1 << TRIG_FRAC);
    rot = wz * rotation_gain_set;
    lin[0] = vy + vx;
    lin[1] = -vy + vx;
    lin[2] = -vy - vx;
    lin[3] = vy - vx;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      // sum in Q20.8, truncate toward zero, saturate to int16
      v = (lin[k] * 256 + rot) / 256;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res[k] = WHEEL_W'(v);
    end
    return res;
  endfunction

  // Sender: drive the next pending command word, idle at random
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        seen_cmd.lateral = cmd_bus.stick_lateral;
        seen_cmd.forward = cmd_bus.stick_forward;
        seen_cmd.rotate  = cmd_bus.stick_rotate;
        seen_cmd.chassis = cmd_bus.chassis_yaw;
        seen_cmd.gimbal  = cmd_bus.gimbal_yaw;
        due_wheels.push_back(mix_wheels(seen_cmd));
        words_in++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          fresh_cmd = cmd_backlog.pop_front();
          cmd_bus.stick_lateral <= fresh_cmd.lateral;
          cmd_bus.stick_forward <= fresh_cmd.forward;
          cmd_bus.stick_rotate  <= fresh_cmd.rotate;
          cmd_bus.chassis_yaw   <= fresh_cmd.chassis;
          cmd_bus.gimbal_yaw    <= fresh_cmd.gimbal;
          cmd_bus.valid <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each wheel word against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      wheel_bus.ready <= 1'b0;
    end else begin
      if (wheel_bus.valid && wheel_bus.ready) begin
        words_out++;
        got_wheels[0] = wheel_bus.wheel_speed_0;
        got_wheels[1] = wheel_bus.wheel_speed_1;
        got_wheels[2] = wheel_bus.wheel_speed_2;
        got_wheels[3] = wheel_bus.wheel_speed_3;
        if (due_wheels.size() == 0) begin
          $display("%0t ns: unexpected wheel word, expected none, got %0d %0d %0d %0d",
                   $time, $signed(got_wheels[0]), $signed(got_wheels[1]),
                   $signed(got_wheels[2]), $signed(got_wheels[3]));
          error_count++;
        end else begin
          fresh_wheels_check(due_wheels.pop_front());
        end
      end
      wheel_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic void fresh_wheels_check(input wheel_set_t want);
    for (int k = 0; k < NUM_WHEELS; k++) begin
      if (got_wheels[k] !== want[k]) begin
        $display("%0t ns: wheel_speed_%0d expected %0d, got %0d", $time, k,
                 $signed(want[k]), $signed(got_wheels[k]));
        error_count++;
      end
    end
  endfunction

  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_back(input reg_idx_t idx, input int want, input logic [31:0] mask);
    logic [31:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if ((rd & mask) !== (want & mask)) begin
      $display("%0t ns: register %s expected %0d, got %0d", $time, idx.name(), want,
               rd & mask);
      error_count++;
    end
  endtask

  // Write both settings with junk in the unused upper bits, then read them back
  task automatic set_config(input int sm, input int gain);
    logic [31:0] rd;
    apb_access(REG_SPEED_MAX, 1'b1, ($urandom & ~32'h3FFF) | sm, rd);
    apb_access(REG_ROTATION_GAIN, 1'b1, ($urandom & ~32'h3FF) | gain, rd);
    speed_max_set = sm & 32'h3FFF;
    rotation_gain_set = gain & 32'h3FF;
    settings_used++;
    read_back(REG_SPEED_MAX, speed_max_set, 32'h3FFF);
    read_back(REG_ROTATION_GAIN, rotation_gain_set, 32'h3FF);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_bus.valid || due_wheels.size() != 0)
      @(posedge clk);
  endtask

  function automatic void add_cmd(input int lat, input int fwd, input int rot,
                                  input int ch, input int gb);
    cmd_word_t c;
    c.lateral = STICK_W'(lat);
    c.forward = STICK_W'(fwd);
    c.rotate  = STICK_W'(rot);
    c.chassis = YAW_W'(ch);
    c.gimbal  = YAW_W'(gb);
    cmd_backlog.push_back(c);
  endfunction

  function automatic int stick_extreme();
    case ($urandom_range(4))
      0: return -660;
      1: return 660;
      2: return 0;
      3: return -1024;
      default: return 1023;
    endcase
  endfunction

  function automatic int rand_stick();
    return int'($urandom_range(1320)) - 660;
  endfunction

  function automatic int rand_yaw();
    return int'($urandom_range(36000)) - 18000;
  endfunction

  function automatic void add_random_cmd();
    int pick, base, turn;
    pick = $urandom_range(99);
    base = rand_yaw();
    if (pick < 65) begin
      add_cmd(rand_stick(), rand_stick(), rand_stick(), rand_yaw(), base);
    end else if (pick < 77) begin
      add_cmd(stick_extreme(), stick_extreme(), stick_extreme(), rand_yaw(), base);
    end else if (pick < 90) begin
      // land close to a quadrant or half-turn boundary of the heading difference
      base = int'($urandom_range(20000)) - 10000;
      turn = (int'($urandom_range(4)) - 2) * ANGLE_QUARTER + int'($urandom_range(4)) - 2;
      add_cmd(rand_stick(), rand_stick(), rand_stick(), base - turn, base);
    end else begin
      add_cmd($urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endfunction

  task automatic run_phase(input int sm, input int gain, input int count,
                           input int src_idle, input int snk_idle);
    wait_drained();
    set_config(sm, gain);
    src_idle_pct = src_idle;
    snk_idle_pct = snk_idle;
    repeat (count) add_random_cmd();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.stick_lateral = '0;
    cmd_bus.stick_forward = '0;
    cmd_bus.stick_rotate = '0;
    cmd_bus.chassis_yaw = '0;
    cmd_bus.gimbal_yaw = '0;
    wheel_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    read_back(REG_SPEED_MAX, SPEED_MAX_RESET, 32'h3FFF);
    read_back(REG_ROTATION_GAIN, ROTATION_GAIN_RESET, 32'h3FF);

    // Directed words under the reset settings
    add_cmd(0, 0, 0, 0, 0);
    add_cmd(660, 660, 660, 0, 0);
    add_cmd(-660, -660, -660, 0, 0);
    add_cmd(1023, -1024, 1023, 0, 0);
    add_cmd(-1024, 1023, -1024, 0, 0);
    add_cmd(660, 0, 0, 0, 0);
    add_cmd(0, 660, 0, 0, 0);
    add_cmd(0, 0, 660, 0, 0);
    add_cmd(660, 330, 0, 4500, 0);
    add_cmd(660, 330, 0, 9000, 0);
    add_cmd(660, 330, 0, -9000, 0);
    add_cmd(660, 330, 0, 9001, 0);
    add_cmd(660, 330, 0, -9001, 0);
    add_cmd(660, 330, 0, 18000, 0);
    add_cmd(660, 330, 0, -18000, 0);
    add_cmd(-500, 200, 100, 18000, -18000);
    add_cmd(-500, 200, 100, -18000, 18000);
    add_cmd(300, -600, -660, 32767, -32768);
    add_cmd(300, -600, 660, -32768, 32767);
    add_cmd(-1, 1, -1, 1, -1);

    run_phase(16383, 1023, 170, 25, 25);
    add_cmd(660, 660, 660, 0, 0);
    add_cmd(-660, -660, -660, 0, 0);
    add_cmd(-1024, -1024, -1024, 9000, 0);
    run_phase(0, 0, 170, 25, 25);
    run_phase(1, 1, 170, 25, 25);
    run_phase(660, 256, 170, 0, 0);
    run_phase($urandom_range(16383), $urandom_range(1023), 170, 25, 25);
    run_phase($urandom_range(16383), $urandom_range(1023), 170, 25, 25);
    run_phase($urandom_range(16383), $urandom_range(1023), 170, 25, 25);
    run_phase(SPEED_MAX_RESET, ROTATION_GAIN_RESET, 170, 25, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d command words and checked %0d wheel words over %0d settings,",
             words_in, words_out, settings_used);
    $display("with random stalls on both channels and directed heading boundaries.");
    if (error_count == 0) begin
      $display("mecanum_wheel_speed_mixer regression: pass");
    end else begin
      $display("mecanum_wheel_speed_mixer regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Timed out with %0d wheel words outstanding", due_wheels.size());
    $display("mecanum_wheel_speed_mixer regression: fail");
    $finish;
  end

endmodule
